/* hdl/sle_pkg.sv */
// Shared types, codes and constants of the sequential list engine.
package sle_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int CMD_W         = 3;
   localparam int POS_W         = 7;
   localparam int DATA_W        = 32;
   localparam int IDX_W         = 6;
   localparam int LEN_W         = 7;
   localparam int CAP_W         = 7;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_DELETE = 3'd2,
      CMD_GET    = 3'd3,
      CMD_LOCATE = 3'd4,
      CMD_PRIOR  = 3'd5,
      CMD_NEXT   = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_SHIFT,
      ST_INS_WRITE,
      ST_DEL_SHIFT,
      ST_RD_ISSUE,
      ST_RD_WAIT,
      ST_SEARCH,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] data_in;
   } req_payload_type;

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] data_out;
      logic [IDX_W-1:0]         index_out;
      logic [LEN_W-1:0]         length;
   } rsp_payload_type;

   typedef logic [CAP_W-1:0] csr_payload_type;

   typedef struct packed {
      logic start;
      logic ack;
   } seq_ctl_type;

   typedef struct packed {
      logic            idle;
      logic            done;
      rsp_payload_type result;
   } seq_stat_type;

endpackage

/* hdl/sle_chan_if.sv */
// Valid/ready channel interface carrying one payload type.
interface sle_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/sequential_list_engine.sv */
// Top level of the sequential list engine: channels, capacity register, result register.
//
//   channel   dir  payload                                  
//   req_chan  in   command, position, data_in               
//   rsp_chan  out  ok, data_out, index_out, length          
//   csr_chan  in   capacity (always ready)                  
//
// Insert moves every word from position to the end of the list up one place, and delete moves
// the words behind position down; search reads from index 0 to the first match (prior/next then read a neighbour).
// The entry RAM is read and written once per cycle.
// Reset empties the list and sets capacity to 64; stored words are not cleared.
// A finished request waits in the result register; the next request is taken
// meanwhile, and the sequencer holds its own result until that register frees.
module sequential_list_engine #(
   parameter int DEPTH = sle_pkg::DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   sle_chan_if.sink   req_chan,
   sle_chan_if.source rsp_chan,
   sle_chan_if.sink   csr_chan
);
   sle_pkg::csr_payload_type capacity_ff, capacity_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   sle_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;
   sle_pkg::seq_ctl_type     ctl;
   sle_pkg::seq_stat_type    stat;
   logic                     load;

   sle_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req      (req_chan.payload),
      .capacity (capacity_ff),
      .stat     (stat)
   );

   assign req_chan.ready = stat.idle;
   assign csr_chan.ready = 1'b1;

   assign load      = stat.done && (!rsp_valid_ff || rsp_chan.ready);
   assign ctl.start = req_chan.valid && stat.idle;
   assign ctl.ack   = load;

   always_comb begin
      capacity_in    = capacity_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_payload_in = rsp_payload_ff;
      if (csr_chan.valid) begin
         capacity_in = csr_chan.payload;
      end
      if (load) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = stat.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= sle_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;
endmodule

/* hdl/sle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/sle_seq.sv */
// Command sequencer: walks the entry store one word per cycle for shift and search.
module sle_seq #(
   parameter int DEPTH = sle_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sle_pkg::seq_ctl_type          ctl,
   input  sle_pkg::req_payload_type      req,
   input  logic [sle_pkg::CAP_W-1:0]     capacity,
   output sle_pkg::seq_stat_type         stat
);
   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int LW  = (CW > sle_pkg::CAP_W) ? CW : sle_pkg::CAP_W;
   localparam int DW  = sle_pkg::DATA_W;
   localparam int IW  = sle_pkg::IDX_W;
   localparam int NW  = sle_pkg::LEN_W;
   localparam logic [LW-1:0] DEPTH_X = LW'(DEPTH);

   sle_pkg::state_type state_ff, state_in;
   sle_pkg::cmd_type   cmd_ff, cmd_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [DW-1:0]      val_ff, val_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic [CW-1:0]      rem_ff, rem_in;
   logic [AW-1:0]      wptr_ff, wptr_in;
   logic               pend_ff, pend_in;
   logic               pfirst_ff, pfirst_in;
   logic               ok_ff, ok_in;
   logic [DW-1:0]      dout_ff, dout_in;
   logic [AW-1:0]      idx_ff, idx_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [DW-1:0]      ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [DW-1:0]      ram_rdata;

   logic [LW-1:0]      pos_x;
   logic [LW-1:0]      cnt_x;
   logic [LW-1:0]      cap_x;
   logic [CW-1:0]      req_pos;
   logic [CW-1:0]      next_idx;
   logic               match;

   sle_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign pos_x    = LW'(req.position);
   assign cnt_x    = LW'(cnt_ff);
   assign cap_x    = LW'(capacity);
   assign req_pos  = CW'(req.position);
   assign next_idx = CW'(wptr_ff) + 1'b1;
   assign match    = (ram_rdata == val_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sle_pkg::ST_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      ptr_ff    <= ptr_in;
      rem_ff    <= rem_in;
      wptr_ff   <= wptr_in;
      pfirst_ff <= pfirst_in;
      ok_ff     <= ok_in;
      dout_ff   <= dout_in;
      idx_ff    <= idx_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      cnt_in    = cnt_ff;
      ptr_in    = ptr_ff;
      rem_in    = rem_ff;
      wptr_in   = wptr_ff;
      pend_in   = 1'b0;
      pfirst_in = pfirst_ff;
      ok_in     = ok_ff;
      dout_in   = dout_ff;
      idx_in    = idx_ff;
      ram_we    = 1'b0;
      ram_waddr = wptr_ff;
      ram_wdata = ram_rdata;
      ram_raddr = ptr_ff[AW-1:0];

      case (state_ff)
         sle_pkg::ST_IDLE: begin
            if (ctl.start) begin
               cmd_in   = sle_pkg::cmd_type'(req.command);
               pos_in   = req_pos;
               val_in   = req.data_in;
               ok_in    = 1'b0;
               dout_in  = '0;
               idx_in   = '0;
               state_in = sle_pkg::ST_RESULT;
               case (sle_pkg::cmd_type'(req.command))
                  sle_pkg::CMD_CLEAR: begin
                     cnt_in = '0;
                     ok_in  = 1'b1;
                  end
                  sle_pkg::CMD_INSERT: begin
                     if (pos_x <= cnt_x && cnt_x < cap_x && cnt_x < DEPTH_X) begin
                        ptr_in   = cnt_ff - 1'b1;
                        rem_in   = cnt_ff - req_pos;
                        state_in = sle_pkg::ST_INS_SHIFT;
                     end
                  end
                  sle_pkg::CMD_DELETE: begin
                     if (pos_x < cnt_x) begin
                        ptr_in   = req_pos;
                        rem_in   = cnt_ff - req_pos;
                        state_in = sle_pkg::ST_DEL_SHIFT;
                     end
                  end
                  sle_pkg::CMD_GET: begin
                     if (pos_x < cnt_x) begin
                        ptr_in   = req_pos;
                        state_in = sle_pkg::ST_RD_ISSUE;
                     end
                  end
                  sle_pkg::CMD_LOCATE, sle_pkg::CMD_PRIOR, sle_pkg::CMD_NEXT: begin
                     if (cnt_ff != '0) begin
                        ptr_in   = '0;
                        rem_in   = cnt_ff;
                        state_in = sle_pkg::ST_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         sle_pkg::ST_INS_SHIFT: begin
            // move the word read last cycle up one place
            if (pend_ff) begin
               ram_we = 1'b1;
            end
            if (rem_ff != '0) begin
               pend_in = 1'b1;
               wptr_in = ptr_ff[AW-1:0] + 1'b1;
               ptr_in  = ptr_ff - 1'b1;
               rem_in  = rem_ff - 1'b1;
            end else begin
               state_in = sle_pkg::ST_INS_WRITE;
            end
         end

         sle_pkg::ST_INS_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff[AW-1:0];
            ram_wdata = val_ff;
            cnt_in    = cnt_ff + 1'b1;
            ok_in     = 1'b1;
            state_in  = sle_pkg::ST_RESULT;
         end

         sle_pkg::ST_DEL_SHIFT: begin
            // first word read is the removed entry, the rest move down
            if (pend_ff) begin
               if (pfirst_ff) begin
                  dout_in = ram_rdata;
               end else begin
                  ram_we = 1'b1;
               end
            end
            if (rem_ff != '0) begin
               pend_in   = 1'b1;
               pfirst_in = (ptr_ff == pos_ff);
               wptr_in   = ptr_ff[AW-1:0] - 1'b1;
               ptr_in    = ptr_ff + 1'b1;
               rem_in    = rem_ff - 1'b1;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               ok_in    = 1'b1;
               state_in = sle_pkg::ST_RESULT;
            end
         end

         sle_pkg::ST_RD_ISSUE: begin
            state_in = sle_pkg::ST_RD_WAIT;
         end

         sle_pkg::ST_RD_WAIT: begin
            dout_in  = ram_rdata;
            ok_in    = 1'b1;
            state_in = sle_pkg::ST_RESULT;
         end

         sle_pkg::ST_SEARCH: begin
            if (pend_ff && match) begin
               state_in = sle_pkg::ST_RESULT;
               case (cmd_ff)
                  sle_pkg::CMD_LOCATE: begin
                     ok_in  = 1'b1;
                     idx_in = wptr_ff;
                  end
                  sle_pkg::CMD_PRIOR: begin
                     if (wptr_ff != '0) begin
                        ptr_in   = CW'(wptr_ff) - 1'b1;
                        state_in = sle_pkg::ST_RD_ISSUE;
                     end
                  end
                  sle_pkg::CMD_NEXT: begin
                     if (next_idx < cnt_ff) begin
                        ptr_in   = next_idx;
                        state_in = sle_pkg::ST_RD_ISSUE;
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (rem_ff != '0) begin
               pend_in = 1'b1;
               wptr_in = ptr_ff[AW-1:0];
               ptr_in  = ptr_ff + 1'b1;
               rem_in  = rem_ff - 1'b1;
            end else begin
               state_in = sle_pkg::ST_RESULT;
            end
         end

         sle_pkg::ST_RESULT: begin
            if (ctl.ack) begin
               state_in = sle_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sle_pkg::ST_IDLE;
         end
      endcase
   end

   assign stat.idle             = (state_ff == sle_pkg::ST_IDLE);
   assign stat.done             = (state_ff == sle_pkg::ST_RESULT);
   assign stat.result.ok        = ok_ff;
   assign stat.result.data_out  = dout_ff;
   assign stat.result.index_out = IW'(idx_ff);
   assign stat.result.length    = NW'(cnt_ff);
endmodule

/* verif/tb_sequential_list_engine.sv */
// Testbench for the sequential list engine: directed and random requests against a list model.
module tb_sequential_list_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                        DEPTH        = sle_pkg::DEPTH_DEFAULT;
   localparam logic [sle_pkg::CMD_W-1:0] CMD_UNUSED   = 3'd7;
   localparam int                        DRAIN_CYCLES = DEPTH + 8;

   logic clock;
   logic reset;

   sle_chan_if #(.payload_type(sle_pkg::req_payload_type)) req_if ();
   sle_chan_if #(.payload_type(sle_pkg::rsp_payload_type)) rsp_if ();
   sle_chan_if #(.payload_type(sle_pkg::csr_payload_type)) csr_if ();

   sequential_list_engine #(.DEPTH(DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   logic signed [sle_pkg::DATA_W-1:0] list_words [DEPTH];
   int                                list_len     = 0;
   int                                capacity_reg = 64;
   sle_pkg::rsp_payload_type          expected_results [$];
   int                                fail_count   = 0;
   bit                                req_held     = 1'b0;
   bit                                idle_enable  = 1'b1;
   bit                                stall_enable = 1'b1;
   int                                stall_left   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("sequential_list_engine test failed");
      $finish;
   end

   function automatic sle_pkg::rsp_payload_type predict_list_result(
      input sle_pkg::req_payload_type req);
      sle_pkg::rsp_payload_type r;
      int                       limit;
      int                       hit;
      int                       pos;
      int                       i;
      r     = '0;
      pos   = req.position;
      limit = (capacity_reg < DEPTH) ? capacity_reg : DEPTH;
      hit   = list_len;
      for (i = list_len - 1; i >= 0; i--) begin
         if (list_words[i] == req.data_in) hit = i;
      end
      case (req.command)
         sle_pkg::CMD_CLEAR: begin
            list_len = 0;
            r.ok     = 1'b1;
         end
         sle_pkg::CMD_INSERT: begin
            if (pos <= list_len && list_len < limit) begin
               for (i = list_len; i > pos; i--) list_words[i] = list_words[i - 1];
               list_words[pos] = req.data_in;
               list_len++;
               r.ok = 1'b1;
            end
         end
         sle_pkg::CMD_DELETE: begin
            if (pos < list_len) begin
               r.data_out = list_words[pos];
               for (i = pos + 1; i < list_len; i++) list_words[i - 1] = list_words[i];
               list_len--;
               r.ok = 1'b1;
            end
         end
         sle_pkg::CMD_GET: begin
            if (pos < list_len) begin
               r.data_out = list_words[pos];
               r.ok       = 1'b1;
            end
         end
         sle_pkg::CMD_LOCATE: begin
            if (hit < list_len) begin
               r.index_out = hit[sle_pkg::IDX_W-1:0];
               r.ok        = 1'b1;
            end
         end
         sle_pkg::CMD_PRIOR: begin
            if (hit < list_len && hit > 0) begin
               r.data_out = list_words[hit - 1];
               r.ok       = 1'b1;
            end
         end
         sle_pkg::CMD_NEXT: begin
            if (hit + 1 < list_len) begin
               r.data_out = list_words[hit + 1];
               r.ok       = 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.length = list_len[sle_pkg::LEN_W-1:0];
      return r;
   endfunction

   function automatic logic signed [sle_pkg::DATA_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom_range(0, 7) - 4;
         3:       return 32'h8000_0000;
         4:       return 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic void check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (stall_enable && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      sle_pkg::rsp_payload_type got;
      sle_pkg::rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual ok=%0d data_out=%0d",
                     $time, got.ok, got.data_out,
                     " index_out=%0d length=%0d", got.index_out, got.length);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("ok", want.ok, got.ok);
            check_field("data_out", want.data_out, got.data_out);
            check_field("index_out", want.index_out, got.index_out);
            check_field("length", want.length, got.length);
         end
      end
   end

   task automatic send_request(input logic [sle_pkg::CMD_W-1:0] command, input int position,
                               input logic signed [sle_pkg::DATA_W-1:0] value);
      sle_pkg::req_payload_type req;
      req.command  = command;
      req.position = position[sle_pkg::POS_W-1:0];
      req.data_in  = value;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         if (req_held) begin
            req_if.valid <= 1'b0;
            req_held = 1'b0;
         end
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_if.payload <= req;
      req_if.valid   <= 1'b1;
      req_held = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      expected_results.push_back(predict_list_result(req));
   endtask

   task automatic wait_drained();
      if (req_held) begin
         req_if.valid <= 1'b0;
         req_held = 1'b0;
      end
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input int value);
      wait_drained();
      csr_if.payload <= value[sle_pkg::CAP_W-1:0];
      csr_if.valid   <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      capacity_reg = value;
   endtask

   task automatic test_list_basics();
      send_request(sle_pkg::CMD_GET, 0, 0);
      send_request(sle_pkg::CMD_DELETE, 0, 0);
      send_request(sle_pkg::CMD_LOCATE, 0, 5);
      send_request(sle_pkg::CMD_INSERT, 0, 32'h7fff_ffff);
      send_request(sle_pkg::CMD_INSERT, 1, 32'h8000_0000);
      send_request(sle_pkg::CMD_INSERT, 3, 1);
      send_request(sle_pkg::CMD_INSERT, 1, -1);
      send_request(sle_pkg::CMD_INSERT, 0, 0);
      send_request(sle_pkg::CMD_INSERT, 4, 32'h5555_5555);
      send_request(sle_pkg::CMD_INSERT, 2, 32'haaaa_aaaa);
      send_request(sle_pkg::CMD_INSERT, 6, -1);
      send_request(sle_pkg::CMD_GET, 6, 0);
      send_request(sle_pkg::CMD_GET, 7, 0);
      send_request(sle_pkg::CMD_GET, DEPTH, 0);
      send_request(sle_pkg::CMD_LOCATE, 0, -1);
      send_request(sle_pkg::CMD_PRIOR, 0, 0);
      send_request(sle_pkg::CMD_PRIOR, 0, -1);
      send_request(sle_pkg::CMD_NEXT, 0, -1);
      send_request(sle_pkg::CMD_DELETE, 6, 0);
      send_request(sle_pkg::CMD_NEXT, 0, 32'h5555_5555);
      send_request(sle_pkg::CMD_DELETE, 6, 0);
      send_request(sle_pkg::CMD_DELETE, 1, 0);
      send_request(CMD_UNUSED, 63, 32'h7fff_ffff);
      send_request(sle_pkg::CMD_CLEAR, 0, 0);
      send_request(sle_pkg::CMD_GET, 0, 0);
   endtask

   task automatic test_capacity_limits();
      int k;
      write_capacity(1);
      send_request(sle_pkg::CMD_INSERT, 0, random_word());
      send_request(sle_pkg::CMD_INSERT, 1, random_word());
      send_request(sle_pkg::CMD_INSERT, 0, random_word());
      write_capacity(64);
      for (k = 0; k < 9; k++) begin
         send_request(sle_pkg::CMD_INSERT, $urandom_range(0, list_len), random_word());
      end
      write_capacity(3);
      send_request(sle_pkg::CMD_INSERT, 0, random_word());
      while (list_len > 2) begin
         send_request(sle_pkg::CMD_DELETE, $urandom_range(0, list_len - 1), 0);
      end
      send_request(sle_pkg::CMD_INSERT, list_len, random_word());
      send_request(sle_pkg::CMD_INSERT, 0, random_word());
      write_capacity(64);
   endtask

   task automatic test_fill_to_depth();
      int k;
      send_request(sle_pkg::CMD_CLEAR, 0, 0);
      for (k = 0; k < DEPTH; k++) begin
         send_request(sle_pkg::CMD_INSERT, $urandom_range(0, k), random_word());
      end
      send_request(sle_pkg::CMD_INSERT, 0, random_word());
      send_request(sle_pkg::CMD_GET, DEPTH - 1, 0);
      send_request(sle_pkg::CMD_GET, DEPTH, 0);
      send_request(sle_pkg::CMD_NEXT, 0, list_words[DEPTH - 1]);
      send_request(sle_pkg::CMD_LOCATE, 0, list_words[DEPTH - 1]);
      send_request(sle_pkg::CMD_DELETE, DEPTH - 1, 0);
      while (list_len > DEPTH / 2) begin
         send_request(sle_pkg::CMD_DELETE, $urandom_range(0, list_len - 1), 0);
      end
   endtask

   task automatic random_items(input int total);
      int                                k;
      int                                roll;
      int                                pos;
      logic [sle_pkg::CMD_W-1:0]         command;
      logic signed [sle_pkg::DATA_W-1:0] value;
      for (k = 0; k < total; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) command = sle_pkg::CMD_CLEAR;
         else if (roll < 38) command = sle_pkg::CMD_INSERT;
         else if (roll < 58) command = sle_pkg::CMD_DELETE;
         else if (roll < 72) command = sle_pkg::CMD_GET;
         else if (roll < 84) command = sle_pkg::CMD_LOCATE;
         else if (roll < 90) command = sle_pkg::CMD_PRIOR;
         else if (roll < 96) command = sle_pkg::CMD_NEXT;
         else command = CMD_UNUSED;
         if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, DEPTH);
         else if (command == sle_pkg::CMD_INSERT) pos = $urandom_range(0, list_len);
         else pos = (list_len > 0) ? $urandom_range(0, list_len - 1) : 0;
         if (command >= sle_pkg::CMD_LOCATE && command <= sle_pkg::CMD_NEXT && list_len > 0
             && $urandom_range(0, 3) != 0) begin
            value = list_words[$urandom_range(0, list_len - 1)];
         end else begin
            value = random_word();
         end
         send_request(command, pos, value);
      end
   endtask

   task automatic test_random_phases();
      write_capacity(64);
      random_items(90);
      write_capacity(1);
      random_items(90);
      write_capacity(2);
      random_items(90);
      write_capacity($urandom_range(1, 64));
      random_items(90);
      write_capacity(63);
      random_items(90);
      write_capacity($urandom_range(1, 64));
      random_items(90);
      write_capacity(64);
      idle_enable  = 1'b0;
      stall_enable = 1'b0;
      random_items(80);
   endtask

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_if.valid   = 1'b0;
      csr_if.payload = sle_pkg::CAP_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_list_basics();
      test_capacity_limits();
      test_fill_to_depth();
      test_random_phases();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("sequential_list_engine test passed");
      end else begin
         $display("sequential_list_engine test failed");
      end
      $finish;
   end

endmodule
